FILE: rtl/core/arpc_pkg.sv
// Shared types and codes for the address resolution cache.
`default_nettype none
package arpc_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_LEARN  = 2'd1,
    OP_QUEUE  = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_LEARN   = 3'd1,
    KIND_QUEUE   = 3'd2,
    KIND_SEND    = 3'd3,
    KIND_UNREACH = 3'd4,
    KIND_TICK    = 3'd5
  } kind_e;

  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_ATTEMPTS = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        hit;
    logic [47:0] mac_out;
    logic [31:0] ip_out;
    logic        table_full;
    logic [3:0]  attempt;
    logic        last;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/arpc_front.sv
// Front end: input register that takes and holds one transaction for the back end.
`default_nettype none
module arpc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire arpc_pkg::req_t in_data_i,
  output logic               q_valid_o,
  input  wire logic          q_pop_i,
  output arpc_pkg::req_t     q_data_o
);
  logic           full_q;
  arpc_pkg::req_t data_q;

  assign in_stall_o = full_q;
  assign q_valid_o  = full_q;
  assign q_data_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_valid_i && !full_q) begin
      full_q <= 1'b1;
    end else if (q_pop_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !full_q) begin
      data_q <= in_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> full_q)
    else $error("pop of empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && !q_pop_i) |=> $stable(data_q))
    else $error("queued transaction changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |=> !full_q)
    else $error("queue not freed after pop");
endmodule
`default_nettype wire

FILE: rtl/core/arpc_back.sv
// Back end: sequencer that scans cache and pending slots and emits results.
`default_nettype none
module arpc_back #(
  parameter int CacheEntries   = 16,
  parameter int PendingEntries = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [15:0]    cfg_data_i,
  input  wire logic           q_valid_i,
  output logic                q_pop_o,
  input  wire arpc_pkg::req_t q_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output arpc_pkg::rsp_t      out_data_o
);
  localparam int CW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int PW = (PendingEntries > 1) ? $clog2(PendingEntries) : 1;
  localparam logic [CW-1:0] CLast = CW'(CacheEntries - 1);
  localparam logic [PW-1:0] PLast = PW'(PendingEntries - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PSCAN, S_CSCAN, S_AGE, S_PEND, S_EMIT
  } state_e;

  state_e state_q;
  logic [15:0] timeout_q;
  logic [3:0]  attempts_q;
  logic [7:0]  interval_q;
  logic [31:0] now_q;

  logic [CacheEntries-1:0]   evalid_q;
  logic [31:0] eip_q   [CacheEntries];
  logic [47:0] emac_q  [CacheEntries];
  logic [31:0] eadd_q  [CacheEntries];
  logic [PendingEntries-1:0] pvalid_q;
  logic [31:0] pip_q   [PendingEntries];
  logic [31:0] psent_q [PendingEntries];
  logic [3:0]  pcnt_q  [PendingEntries];

  arpc_pkg::req_t req_q;
  logic [CW-1:0]  ci_q;
  logic [PW-1:0]  pi_q;
  logic           found_q;
  logic [47:0]    mac_q;
  logic           ffound_q;
  logic [PW-1:0]  fslot_q;
  logic           ovalid_q;
  arpc_pkg::rsp_t out_q;
  logic           pend_done_q;

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;

  logic [31:0] age, since;
  logic        due;
  logic        load_out;
  assign age   = now_q - eadd_q[ci_q];
  assign since = now_q - psent_q[pi_q];
  assign due   = (pcnt_q[pi_q] == 4'd0) || (since >= {24'd0, interval_q});
  // a new result goes into the output register this cycle
  assign load_out = (!ovalid_q || !out_stall_i) &&
                    ((state_q == S_EMIT) ||
                     ((state_q == S_PEND) && (pend_done_q || (pvalid_q[pi_q] && due))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      timeout_q   <= 16'd15;
      attempts_q  <= 4'd5;
      interval_q  <= 8'd1;
      now_q       <= '0;
      evalid_q    <= '0;
      pvalid_q    <= '0;
      ovalid_q    <= 1'b0;
      ci_q        <= '0;
      pi_q        <= '0;
      found_q     <= 1'b0;
      ffound_q    <= 1'b0;
      fslot_q     <= '0;
      pend_done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          arpc_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
          arpc_pkg::CFG_ATTEMPTS: attempts_q <= cfg_data_i[3:0];
          arpc_pkg::CFG_INTERVAL: interval_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (load_out) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            ci_q     <= '0;
            pi_q     <= '0;
            found_q  <= 1'b0;
            ffound_q <= 1'b0;
            mac_q    <= '0;
            pend_done_q <= 1'b0;
            case (arpc_pkg::op_e'(q_data_i.opcode))
              arpc_pkg::OP_LOOKUP: state_q <= S_CSCAN;
              arpc_pkg::OP_TICK: begin
                now_q   <= now_q + 32'd1;
                state_q <= S_AGE;
              end
              default: state_q <= S_PSCAN;
            endcase
          end
        end
        S_PSCAN: begin
          // learn drops the first match; queue looks for a match and a free slot
          if (pvalid_q[pi_q] && pip_q[pi_q] == req_q.ip_addr && !found_q) begin
            found_q <= 1'b1;
            if (req_q.opcode == arpc_pkg::OP_LEARN) pvalid_q[pi_q] <= 1'b0;
          end
          if (req_q.opcode == arpc_pkg::OP_QUEUE && !pvalid_q[pi_q] && !ffound_q) begin
            ffound_q <= 1'b1;
            fslot_q  <= pi_q;
          end
          if (pi_q == PLast) begin
            if (req_q.opcode == arpc_pkg::OP_LEARN) begin
              state_q <= S_CSCAN;
            end else begin
              state_q <= S_EMIT;
            end
          end else begin
            pi_q <= pi_q + 1'b1;
          end
        end
        S_CSCAN: begin
          if (req_q.opcode == arpc_pkg::OP_LOOKUP) begin
            if (evalid_q[ci_q] && eip_q[ci_q] == req_q.ip_addr) begin
              found_q <= 1'b1;
              mac_q   <= emac_q[ci_q];
            end
            if (ci_q == CLast) state_q <= S_EMIT;
            else ci_q <= ci_q + 1'b1;
          end else begin
            // learn: take the lowest free slot
            if (!evalid_q[ci_q]) begin
              evalid_q[ci_q] <= 1'b1;
              eip_q[ci_q]    <= req_q.ip_addr;
              emac_q[ci_q]   <= req_q.mac_addr;
              eadd_q[ci_q]   <= now_q;
              ffound_q       <= 1'b1;
              state_q        <= S_EMIT;
            end else if (ci_q == CLast) begin
              state_q <= S_EMIT;
            end else begin
              ci_q <= ci_q + 1'b1;
            end
          end
        end
        S_AGE: begin
          if (evalid_q[ci_q] && age > {16'd0, timeout_q}) evalid_q[ci_q] <= 1'b0;
          if (ci_q == CLast) state_q <= S_PEND;
          else ci_q <= ci_q + 1'b1;
        end
        S_PEND: begin
          if (!ovalid_q || !out_stall_i) begin
            if (pend_done_q) begin
              out_q <= '{kind: arpc_pkg::KIND_TICK, hit: 1'b0, mac_out: '0, ip_out: '0,
                         table_full: 1'b0, attempt: '0, last: 1'b1};
              state_q <= S_IDLE;
            end else begin
              if (pvalid_q[pi_q] && due) begin
                if (pcnt_q[pi_q] >= attempts_q) begin
                  pvalid_q[pi_q] <= 1'b0;
                  out_q <= '{kind: arpc_pkg::KIND_UNREACH, hit: 1'b0, mac_out: '0,
                             ip_out: pip_q[pi_q], table_full: 1'b0,
                             attempt: pcnt_q[pi_q], last: 1'b0};
                end else begin
                  pcnt_q[pi_q]  <= pcnt_q[pi_q] + 4'd1;
                  psent_q[pi_q] <= now_q;
                  out_q <= '{kind: arpc_pkg::KIND_SEND, hit: 1'b0, mac_out: '0,
                             ip_out: pip_q[pi_q], table_full: 1'b0,
                             attempt: pcnt_q[pi_q] + 4'd1, last: 1'b0};
                end
              end
              if (pi_q == PLast) pend_done_q <= 1'b1;
              else pi_q <= pi_q + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!ovalid_q || !out_stall_i) begin
            state_q <= S_IDLE;
            case (arpc_pkg::op_e'(req_q.opcode))
              arpc_pkg::OP_LOOKUP: begin
                out_q <= '{kind: arpc_pkg::KIND_LOOKUP, hit: found_q, mac_out: mac_q,
                           ip_out: '0, table_full: 1'b0, attempt: '0, last: 1'b1};
              end
              arpc_pkg::OP_LEARN: begin
                out_q <= '{kind: arpc_pkg::KIND_LEARN, hit: found_q, mac_out: '0,
                           ip_out: '0, table_full: !ffound_q, attempt: '0, last: 1'b1};
              end
              default: begin
                out_q <= '{kind: arpc_pkg::KIND_QUEUE, hit: 1'b0, mac_out: '0,
                           ip_out: '0, table_full: !found_q && !ffound_q,
                           attempt: '0, last: 1'b1};
                // add at first free slot unless already pending
                if (!found_q && ffound_q) begin
                  pvalid_q[fslot_q] <= 1'b1;
                  pip_q[fslot_q]    <= req_q.ip_addr;
                  psent_q[fslot_q]  <= '0;
                  pcnt_q[fslot_q]   <= '0;
                end
              end
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) req_q <= q_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> $stable(out_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q != S_IDLE)
    else $error("popped transaction not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AGE) |-> !$stable(now_q) || $past(state_q) == S_AGE)
    else $error("tick did not advance time");
endmodule
`default_nettype wire

FILE: rtl/core/arp_cache_with_retry_table.sv
// Lookup scans the cache slots; learn scans the pending slots, then the cache up
// to a free slot; queue scans the pending slots; tick ages every cache slot, then
// scans the pending slots; output stalls add to each. One transaction at a time;
// the back-end slot scan sets the rate. A one-entry input register accepts the
// next transaction while one is in work. Reset (rst_ni low, async) clears cache,
// pending table and time; config returns to timeout 15, attempts 5, interval 1.
`default_nettype none
module arp_cache_with_retry_table #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [15:0]    cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire arpc_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output arpc_pkg::rsp_t      out_data_o
);
  logic           q_valid, q_pop;
  arpc_pkg::req_t q_data;

  arpc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  arpc_back #(.CacheEntries(CACHE_ENTRIES), .PendingEntries(PENDING_ENTRIES)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
`default_nettype wire
